[hw/rtl/c2u_pkg.sv]
// Shared types, constants and the CP850 to UTF-8 table of the converter.
package c2u_pkg;

  localparam int QueueDepth = 2;

  localparam logic [7:0] AsciiLimit = 8'h80;
  localparam logic [7:0] LeadLow    = 8'hC2;
  localparam logic [7:0] LeadHigh   = 8'hF4;

  // One queued job: up to three held bytes plus the current byte
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [3:0]      xlat;   // 1: translate through the table, 0: pass raw
    logic [2:0]      count;  // number of valid entries, 1..4
  } job_t;

  // UTF-8 form of CP850 bytes 0x80..0xFF; top byte zero means two bytes
  localparam logic [23:0] Cp850Utf8 [128] = '{
    24'h00C387, 24'h00C3BC, 24'h00C3A9, 24'h00C3A2, 24'h00C3A4, 24'h00C3A0, 24'h00C3A5,
    24'h00C3A7, 24'h00C3AA, 24'h00C3AB, 24'h00C3A8, 24'h00C3AF, 24'h00C3AE, 24'h00C3AC,
    24'h00C384, 24'h00C385, 24'h00C389, 24'h00C3A6, 24'h00C386, 24'h00C3B4, 24'h00C3B6,
    24'h00C3B2, 24'h00C3BB, 24'h00C3B9, 24'h00C3BF, 24'h00C396, 24'h00C39C, 24'h00C3B8,
    24'h00C2A3, 24'h00C398, 24'h00C397, 24'h00C692, 24'h00C3A1, 24'h00C3AD, 24'h00C3B3,
    24'h00C3BA, 24'h00C3B1, 24'h00C391, 24'h00C2AA, 24'h00C2BA, 24'h00C2BF, 24'h00C2AE,
    24'h00C2AC, 24'h00C2BD, 24'h00C2BC, 24'h00C2A1, 24'h00C2AB, 24'h00C2BB, 24'hE29691,
    24'hE29692, 24'hE29693, 24'hE29482, 24'hE294A4, 24'h00C381, 24'h00C382, 24'h00C380,
    24'h00C2A9, 24'hE295A3, 24'hE29591, 24'hE29597, 24'hE2959D, 24'h00C2A2, 24'h00C2A5,
    24'hE29490, 24'hE29494, 24'hE294B4, 24'hE294AC, 24'hE2949C, 24'hE29480, 24'hE294BC,
    24'h00C3A3, 24'h00C383, 24'hE2959A, 24'hE29594, 24'hE295A9, 24'hE295A6, 24'hE295A0,
    24'hE29590, 24'hE295AC, 24'h00C2A4, 24'h00C3B0, 24'h00C390, 24'h00C38A, 24'h00C38B,
    24'h00C388, 24'h00C4B1, 24'h00C38D, 24'h00C38E, 24'h00C38F, 24'hE29498, 24'hE2948C,
    24'hE29688, 24'hE29684, 24'h00C2A6, 24'h00C38C, 24'hE29680, 24'h00C393, 24'h00C39F,
    24'h00C394, 24'h00C392, 24'h00C3B5, 24'h00C395, 24'h00C2B5, 24'h00C3BE, 24'h00C39E,
    24'h00C39A, 24'h00C39B, 24'h00C399, 24'h00C3BD, 24'h00C39D, 24'h00C2AF, 24'h00C2B4,
    24'h00C2AD, 24'h00C2B1, 24'hE28097, 24'h00C2BE, 24'h00C2B6, 24'h00C2A7, 24'h00C3B7,
    24'h00C2B8, 24'h00C2B0, 24'h00C2A8, 24'h00C2B7, 24'h00C2B9, 24'h00C2B3, 24'h00C2B2,
    24'hE296A0, 24'h00C2A0
  };

endpackage

[hw/rtl/c2u_front.sv]
// Front end: tracks open UTF-8 sequences and turns input bytes into jobs.
module c2u_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    data_byte,
  input  logic          end_of_text,
  output logic          push,
  output c2u_pkg::job_t push_job,
  input  logic          queue_full
);
  import c2u_pkg::*;

  logic [2:0][7:0] held_bytes, held_bytes_next;
  logic [1:0]      held_count, held_count_next;
  logic [2:0]      sequence_length, sequence_length_next;

  logic       accept;
  logic       is_cont, is_lead;
  logic [2:0] need;
  logic [1:0] hn;        // held bytes placed ahead of the current byte
  logic       held_xl;   // held bytes translated (sequence broken)
  logic       b_xl;      // current byte translated
  logic       b_out;     // current byte emitted now
  job_t       job;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;

  // Classify the current byte
  always_comb begin
    is_cont = (data_byte[7:6] == 2'b10);
    is_lead = (data_byte >= LeadLow) && (data_byte <= LeadHigh);
    if (data_byte[7:5] == 3'b110) begin
      need = 3'd2;
    end else if (data_byte[7:4] == 4'hE) begin
      need = 3'd3;
    end else begin
      need = 3'd4;
    end
  end

  // Decide what this byte emits and what stays held
  always_comb begin
    hn                   = 2'd0;
    held_xl              = 1'b1;
    b_xl                 = 1'b1;
    b_out                = 1'b1;
    held_bytes_next      = held_bytes;
    held_count_next      = 2'd0;
    sequence_length_next = 3'd0;
    if (held_count != 2'd0 && is_cont) begin
      hn = held_count;
      if ({1'b0, held_count} + 3'd1 >= sequence_length) begin
        held_xl = 1'b0;
        b_xl    = 1'b0;
      end else if (!end_of_text) begin
        b_out                = 1'b0;
        hn                   = 2'd0;
        held_bytes_next[held_count] = data_byte;
        held_count_next      = held_count + 2'd1;
        sequence_length_next = sequence_length;
      end
    end else begin
      hn = held_count;
      if (data_byte < AsciiLimit) begin
        b_xl = 1'b0;
      end else if (is_lead && !end_of_text) begin
        b_out                = 1'b0;
        held_bytes_next[0]   = data_byte;
        held_count_next      = 2'd1;
        sequence_length_next = need;
      end
    end
  end

  // Assemble the job
  always_comb begin
    job.bytes     = {8'h00, held_bytes};
    job.bytes[hn] = data_byte;
    job.xlat      = 4'b0000;
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < hn) begin
        job.xlat[i] = held_xl;
      end
    end
    job.xlat[hn] = b_xl;
    job.count    = {1'b0, hn} + {2'b00, b_out};
  end

  assign push     = accept && (job.count != 3'd0);
  assign push_job = job;

  // Held sequence state
  always_ff @(posedge clk) begin
    if (rst) begin
      held_bytes      <= '0;
      held_count      <= 2'd0;
      sequence_length <= 3'd0;
    end else if (accept) begin
      held_bytes      <= held_bytes_next;
      held_count      <= held_count_next;
      sequence_length <= sequence_length_next;
    end
  end

endmodule

[hw/rtl/c2u_queue.sv]
// Short job queue between the front end and the byte expander.
module c2u_queue #(
  parameter int Depth = c2u_pkg::QueueDepth
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  c2u_pkg::job_t push_job,
  output logic          full,
  input  logic          pop,
  output logic          not_empty,
  output c2u_pkg::job_t head_job
);
  import c2u_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  job_t            slots [Depth];
  logic [PtrW-1:0] wr_ptr, rd_ptr;
  logic [CntW-1:0] fill;

  assign full      = (fill == CntW'(Depth));
  assign not_empty = (fill != '0);
  assign head_job  = slots[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        fill <= fill + 1'b1;
      end else if (pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

[hw/rtl/c2u_back.sv]
// Back end: expands each job entry into one to three output bytes.
module c2u_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          job_valid,
  input  c2u_pkg::job_t job,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_ready,
  output logic [7:0]    out_byte,
  output logic          last_of_run
);
  import c2u_pkg::*;

  logic [1:0]  ent, byte_idx;
  logic [7:0]  cur;
  logic [23:0] code;
  logic [1:0]  nbytes;
  logic [1:0]  sel;
  logic [7:0]  byte_now;
  logic        last_byte, last_ent, advance;

  // Current entry and its table code
  always_comb begin
    cur    = job.bytes[ent];
    code   = Cp850Utf8[cur[6:0]];
    nbytes = !job.xlat[ent] ? 2'd1 : ((code[23:16] != 8'h00) ? 2'd3 : 2'd2);
    sel    = byte_idx + (2'd3 - nbytes);
    case (sel)
      2'd0:    byte_now = code[23:16];
      2'd1:    byte_now = code[15:8];
      default: byte_now = code[7:0];
    endcase
    if (!job.xlat[ent]) begin
      byte_now = cur;
    end
  end

  assign last_byte = (byte_idx == nbytes - 2'd1);
  assign last_ent  = ({1'b0, ent} == job.count - 3'd1);
  assign advance   = job_valid && (!out_valid || out_ready);
  assign pop       = advance && last_byte && last_ent;

  // Walk entries and bytes
  always_ff @(posedge clk) begin
    if (rst) begin
      ent      <= 2'd0;
      byte_idx <= 2'd0;
    end else if (advance) begin
      if (last_byte) begin
        byte_idx <= 2'd0;
        ent      <= last_ent ? 2'd0 : ent + 2'd1;
      end else begin
        byte_idx <= byte_idx + 2'd1;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_byte    <= byte_now;
      last_of_run <= last_byte && last_ent;
    end
  end

endmodule

[hw/rtl/cp850_to_utf8_passthrough_top.sv]
// Top level of the CP850 to UTF-8 pass-through converter.
//
//   channel | valid / ready          | payload
//   input   | in_valid / in_ready    | data_byte, end_of_text
//   output  | out_valid / out_ready  | out_byte, last_of_run
//
// The front end takes one byte per cycle while the job queue has room.
// The back end emits one UTF-8 byte per cycle unless stalled; an input yields
// 0 to 12 bytes (raw 1, translated 2 or 3); output bandwidth sets the rate.
// Synchronous reset empties the queue and drops any held sequence.
// Either side may stall; the queue and the output register decouple them.
module cp850_to_utf8_passthrough_top #(
  parameter int QueueDepth = c2u_pkg::QueueDepth
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] data_byte,
  input  logic       end_of_text,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       last_of_run
);
  import c2u_pkg::*;

  logic push, full, pop, not_empty;
  job_t push_job, head_job;

  c2u_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .end_of_text(end_of_text),
    .push(push), .push_job(push_job), .queue_full(full)
  );

  c2u_queue #(.Depth(QueueDepth)) u_queue (
    .clk(clk), .rst(rst),
    .push(push), .push_job(push_job), .full(full),
    .pop(pop), .not_empty(not_empty), .head_job(head_job)
  );

  c2u_back u_back (
    .clk(clk), .rst(rst),
    .job_valid(not_empty), .job(head_job), .pop(pop),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_byte(out_byte), .last_of_run(last_of_run)
  );

endmodule

[verif/tb_cp850_to_utf8_passthrough_top.sv]
// Testbench for the CP850 to UTF-8 pass-through converter: directed and random texts.
`timescale 1ns / 100ps
module tb_cp850_to_utf8_passthrough_top;
  import c2u_pkg::*;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] data_byte = 8'h00;
  logic       end_of_text = 1'b0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_byte;
  logic       last_of_run;

  cp850_to_utf8_passthrough_top u_top (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready),
    .data_byte(data_byte), .end_of_text(end_of_text), .out_valid(out_valid),
    .out_ready(out_ready), .out_byte(out_byte), .last_of_run(last_of_run)
  );

  // Predictor state: held sequence bytes
  logic [7:0] seq_held [3];
  int         seq_cnt = 0;
  int         seq_len = 0;
  logic [8:0] utf8_q [$];       // {last_of_run, out_byte}
  logic [8:0] step_out [$];
  int         errors = 0;
  bit         quiet_in = 1'b0;
  bit         quiet_out = 1'b0;

  initial forever #6 clk = ~clk;

  initial begin
    #5_000_000;
    $display("** cp850_to_utf8_passthrough_top: FAILED **");
    $finish;
  end

  function automatic void push_raw(logic [7:0] b);
    step_out.push_back({1'b0, b});
  endfunction

  function automatic void push_cp850(logic [7:0] b);
    logic [23:0] v;
    v = Cp850Utf8[b[6:0]];
    if (v[23:16] != 8'h00) push_raw(v[23:16]);
    push_raw(v[15:8]);
    push_raw(v[7:0]);
  endfunction

  function automatic void flush_seq();
    for (int i = 0; i < seq_cnt; i++) push_cp850(seq_held[i]);
    seq_cnt = 0;
    seq_len = 0;
  endfunction

  function automatic void start_byte(logic [7:0] b);
    if (b < AsciiLimit) push_raw(b);
    else if (b >= LeadLow && b <= LeadHigh) begin
      seq_held[0] = b;
      seq_cnt = 1;
      seq_len = (b[7:5] == 3'b110) ? 2 : (b[7:4] == 4'b1110) ? 3 : 4;
    end else push_cp850(b);
  endfunction

  // Work out the output bytes of one accepted input byte
  function automatic void predict_utf8(logic [7:0] b, logic eot);
    step_out.delete();
    if (seq_cnt == 0) start_byte(b);
    else if (b[7:6] == 2'b10) begin
      if (seq_cnt + 1 >= seq_len) begin
        for (int i = 0; i < seq_cnt; i++) push_raw(seq_held[i]);
        push_raw(b);
        seq_cnt = 0;
        seq_len = 0;
      end else begin
        seq_held[seq_cnt] = b;
        seq_cnt++;
      end
    end else begin
      flush_seq();
      start_byte(b);
    end
    if (eot && seq_cnt != 0) flush_seq();
    if (step_out.size() > 0) step_out[$][8] = 1'b1;
    foreach (step_out[i]) utf8_q.push_back(step_out[i]);
  endfunction

  // Valid stays high from one transfer to the next unless an idle gap is drawn
  task automatic send_byte(logic [7:0] b, logic eot);
    if (!quiet_in && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid    <= 1'b1;
    data_byte   <= b;
    end_of_text <= eot;
    do @(posedge clk); while (!in_ready);
    predict_utf8(b, eot);
  endtask

  // Receiver stalls and per-transfer check
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        if (utf8_q.size() == 0) begin
          $display("%0t: unexpected byte %h last %b", $time, out_byte, last_of_run);
          errors++;
        end else begin
          logic [8:0] exp_b;
          exp_b = utf8_q.pop_front();
          if (exp_b[7:0] !== out_byte) begin
            $display("%0t: out_byte exp %h got %h", $time, exp_b[7:0], out_byte);
            errors++;
          end
          if (exp_b[8] !== last_of_run) begin
            $display("%0t: last_of_run exp %b got %b", $time, exp_b[8], last_of_run);
            errors++;
          end
        end
      end
      out_ready <= quiet_out || ($urandom_range(99) >= 8);
    end
  end

  task automatic test_directed();
    logic [7:0] d [$];
    logic       e [$];
    d = '{8'h00, 8'h7F, 8'h80, 8'hFF, 8'hC3, 8'hA9, 8'hE2, 8'h82, 8'hAC,
          8'hF0, 8'h9F, 8'h98, 8'h80, 8'hE0, 8'h80, 8'h41, 8'hC2, 8'h00,
          8'hF4, 8'h80, 8'hC1, 8'hF5, 8'hE1, 8'hB0, 8'hC5};
    e = '{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0,
          0, 0, 0, 0, 0, 1, 1};
    foreach (d[i]) send_byte(d[i], e[i]);
  endtask

  task automatic test_random();
    logic [7:0] lead;
    int         n;
    for (int k = 0; k < 235; k++) begin
      quiet_in  = (k >= 80 && k < 130);
      quiet_out = quiet_in;
      if ($urandom_range(99) < 60) begin
        // well-formed or truncated sequence with random content
        lead = 8'($urandom_range(8'hC2, 8'hF4));
        n = (lead < 8'hE0) ? 1 : (lead < 8'hF0) ? 2 : 3;
        if ($urandom_range(3) == 0) n = $urandom_range(0, n - 1);
        send_byte(lead, ($urandom_range(15) == 0));
        for (int j = 0; j < n; j++)
          send_byte({2'b10, 6'($urandom)}, ($urandom_range(15) == 0));
      end else begin
        send_byte(8'($urandom), ($urandom_range(9) == 0));
      end
    end
    send_byte(8'h2E, 1'b1);
    quiet_in  = 1'b0;
    quiet_out = 1'b0;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_random();
    in_valid <= 1'b0;
    while (utf8_q.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("** cp850_to_utf8_passthrough_top: PASSED **");
    else $display("** cp850_to_utf8_passthrough_top: FAILED **");
    $finish;
  end
endmodule

[files.f]
hw/rtl/c2u_pkg.sv
hw/rtl/c2u_front.sv
hw/rtl/c2u_queue.sv
hw/rtl/c2u_back.sv
hw/rtl/cp850_to_utf8_passthrough_top.sv
verif/tb_cp850_to_utf8_passthrough_top.sv
